// ===== src/max_overlap_vector_pair_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MAX_OVERLAP_VECTOR_PAIR_UNIT_DEFINES_SVH
`define MAX_OVERLAP_VECTOR_PAIR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MOPU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MOPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mopu_pkg.sv =====
package mopu_pkg;

    // Store geometry
    localparam int MAX_VECTORS      = 16;
    localparam int MAX_VECTOR_WORDS = 4;
    localparam int DATA_W           = 64;
    localparam int SLOT_W           = $clog2(MAX_VECTORS);
    localparam int WIDX_W           = $clog2(MAX_VECTOR_WORDS);
    localparam int ADDR_W           = SLOT_W + WIDX_W;
    localparam int CNT_W            = $clog2(MAX_VECTORS + 1);
    localparam int LEN_W            = $clog2(MAX_VECTOR_WORDS + 1);
    localparam int POP_W            = $clog2(DATA_W + 1);

    // Field widths
    localparam int CFG_W            = 3;
    localparam int COMMON_W         = 9;
    localparam int WEIGHT_W         = 9;
    localparam int SUM_W            = 10;
    localparam int IDX_W            = 4;
    localparam int OUT_TDATA_W      = 24;
    localparam int OUT_PAD_W        = OUT_TDATA_W - COMMON_W - 2 * IDX_W - 1;

    localparam logic [CFG_W-1:0] VECTOR_WORDS_RESET = CFG_W'(MAX_VECTOR_WORDS);

    // Word write into the vector store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } word_wr_t;

    // Per-slot length and weight, written when a vector closes
    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    len;
        logic [WEIGHT_W-1:0] weight;
    } slot_wr_t;

    // One word step of the pair search
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] i;
        logic [SLOT_W-1:0] j;
        logic [WIDX_W-1:0] w;
        logic              first;
        logic              last;
    } pair_cmd_t;

    // Best pair found so far
    typedef struct packed {
        logic [COMMON_W-1:0] common;
        logic [SLOT_W-1:0]   first;
        logic [SLOT_W-1:0]   second;
        logic [WEIGHT_W-1:0] first_weight;
    } best_t;

    // Popcount of one word, byte counts then a short sum
    function automatic logic [POP_W-1:0] pop64(input logic [DATA_W-1:0] x);
        logic [POP_W-1:0] total;
        logic [3:0]       part;
        total = '0;
        for (int b = 0; b < DATA_W / 8; b++)
        begin
            part = '0;
            for (int k = 0; k < 8; k++)
            begin
                part = part + 4'(x[8 * b + k]);
            end
            total = total + POP_W'(part);
        end
        return total;
    endfunction

    // Clamp the word-count register into 1..MAX_VECTOR_WORDS
    function automatic logic [LEN_W-1:0] words_in_use(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > CFG_W'(MAX_VECTOR_WORDS))
            r = LEN_W'(MAX_VECTOR_WORDS);
        else
            r = LEN_W'(v);
        return r;
    endfunction

endpackage

// ===== src/max_overlap_vector_pair_unit.sv =====
// Channel    | Ports                              | Carries
// -----------+------------------------------------+-------------------------------------------
// cfg        | cfg_we, cfg_wdata[2:0]             | vector_words
// vector in  | s_tvalid/s_tready, s_tdata, s_tlast| data_word; last_vector on tlast
// result out | m_tvalid/m_tready, m_tdata[23:0]   | common_ones, first_index, second_index,
//            |                                    | overflow
//
// Loading takes words while s_tready is high; a stored vector's closing word then goes through a
// close state that writes its weight. The search steps vw words for each of n*(n-1)/2 pairs of n
// stored vectors, one word pair per cycle through the dual-read store and popcount unit.
// Reset is asynchronous; the vector store is not cleared, written lengths mask stale words.
// A finished result waits in the output register while the next set loads; a search only
// ends once that register is free.
module max_overlap_vector_pair_unit
    import mopu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,    // vector_words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,      // [63:0] data_word
    input  logic                   s_tlast,      // last_vector
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata       // [8:0] common_ones, [12:9] first_index,
                                                 // [16:13] second_index, [17] overflow
);

    typedef enum logic [1:0] {ST_LOAD, ST_CLOSE, ST_SEARCH, ST_DRAIN} state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    vw_cfg_reg;
    logic [WIDX_W-1:0]   word_cnt_reg, word_cnt_next;
    logic [CNT_W-1:0]    vec_cnt_reg, vec_cnt_next;
    logic                ovf_reg, ovf_next;
    logic                last_pend_reg, last_pend_next;
    logic [SLOT_W-1:0]   i_reg, i_next;
    logic [SLOT_W-1:0]   j_reg, j_next;
    logic [WIDX_W-1:0]   w_reg, w_next;
    logic                out_valid_reg, out_valid_next;
    logic [COMMON_W-1:0] out_common_reg, out_common_next;
    logic [IDX_W-1:0]    out_first_reg, out_first_next;
    logic [IDX_W-1:0]    out_second_reg, out_second_next;
    logic                out_ovf_reg, out_ovf_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [POP_W-1:0]    pc_reg [MAX_VECTOR_WORDS];
    logic [POP_W-1:0]    pc_next [MAX_VECTOR_WORDS];

    logic [LEN_W-1:0]    vw;
    logic [WIDX_W-1:0]   vw_last;
    logic                accept;
    logic                room;
    logic [POP_W-1:0]    word_pop;
    logic [LEN_W-1:0]    wc_inc;
    logic                close_vec;
    logic [CNT_W-1:0]    vec_cnt_inc;
    logic [WEIGHT_W-1:0] close_weight;
    logic                swap;
    logic                out_free;

    word_wr_t            word_wr;
    slot_wr_t            slot_wr;
    pair_cmd_t           cmd;
    best_t               best;
    logic                busy;
    logic                clear_best;

    // Shared overlap datapath
    mopu_pair_unit u_pair
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_wr    (word_wr),
        .slot_wr    (slot_wr),
        .clear_best (clear_best),
        .cmd        (cmd),
        .best       (best),
        .busy       (busy)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vw_cfg_reg <= VECTOR_WORDS_RESET;
        else if (cfg_we)
            vw_cfg_reg <= cfg_wdata;
    end

    // Handshake and load-side terms
    assign vw          = words_in_use(vw_cfg_reg);
    assign vw_last     = WIDX_W'(vw - LEN_W'(1));
    assign s_tready    = (state_reg == ST_LOAD);
    assign accept      = s_tvalid && s_tready;
    assign room        = (vec_cnt_reg < CNT_W'(MAX_VECTORS));
    assign word_pop    = pop64(s_tdata);
    assign wc_inc      = LEN_W'(word_cnt_reg) + LEN_W'(1);
    assign close_vec   = (wc_inc >= vw) || s_tlast;
    assign vec_cnt_inc = vec_cnt_reg + CNT_W'(1);
    assign swap        = (best.first_weight == '0);
    assign out_free    = !out_valid_reg || m_tready;
    assign clear_best  = accept && s_tlast;

    // Weight of the closing vector from its per-word counts
    always_comb
    begin
        close_weight = '0;
        for (int k = 0; k < MAX_VECTOR_WORDS; k++)
        begin
            if (LEN_W'(k) < vw)
                close_weight = close_weight + WEIGHT_W'(pc_reg[k]);
        end
    end

    // Store writes and search steps
    always_comb
    begin
        word_wr.en     = accept && room;
        word_wr.addr   = {vec_cnt_reg[SLOT_W-1:0], word_cnt_reg};
        word_wr.data   = s_tdata;
        slot_wr.en     = (state_reg == ST_CLOSE);
        slot_wr.slot   = vec_cnt_reg[SLOT_W-1:0];
        slot_wr.len    = len_reg;
        slot_wr.weight = close_weight;
        cmd.valid      = (state_reg == ST_SEARCH);
        cmd.i          = i_reg;
        cmd.j          = j_reg;
        cmd.w          = w_reg;
        cmd.first      = (w_reg == '0);
        cmd.last       = (w_reg == vw_last);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        word_cnt_next   = word_cnt_reg;
        vec_cnt_next    = vec_cnt_reg;
        ovf_next        = ovf_reg;
        last_pend_next  = last_pend_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        w_next          = w_reg;
        out_valid_next  = out_valid_reg;
        out_common_next = out_common_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_ovf_next    = out_ovf_reg;
        len_next        = len_reg;
        for (int k = 0; k < MAX_VECTOR_WORDS; k++)
        begin
            pc_next[k] = pc_reg[k];
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if ((word_cnt_reg == '0) && !room)
                        ovf_next = 1'b1;
                    // a new vector starts with zero counts for its other words
                    for (int k = 0; k < MAX_VECTOR_WORDS; k++)
                    begin
                        if (WIDX_W'(k) == word_cnt_reg)
                            pc_next[k] = word_pop;
                        else if (word_cnt_reg == '0)
                            pc_next[k] = '0;
                    end
                    if (close_vec)
                    begin
                        word_cnt_next = '0;
                        if (room)
                        begin
                            state_next     = ST_CLOSE;
                            len_next       = wc_inc;
                            last_pend_next = s_tlast;
                        end
                        else if (s_tlast)
                        begin
                            state_next = ST_SEARCH;
                            i_next     = '0;
                            j_next     = SLOT_W'(1);
                            w_next     = '0;
                        end
                    end
                    else
                    begin
                        word_cnt_next = WIDX_W'(wc_inc);
                    end
                end
            end

            ST_CLOSE:
            begin
                vec_cnt_next = vec_cnt_inc;
                if (!last_pend_reg)
                    state_next = ST_LOAD;
                else if (vec_cnt_inc < CNT_W'(2))
                    state_next = ST_DRAIN;
                else
                begin
                    state_next = ST_SEARCH;
                    i_next     = '0;
                    j_next     = SLOT_W'(1);
                    w_next     = '0;
                end
            end

            ST_SEARCH:
            begin
                if (w_reg == vw_last)
                begin
                    w_next = '0;
                    if (CNT_W'(j_reg) == vec_cnt_reg - CNT_W'(1))
                    begin
                        if (CNT_W'(i_reg) + CNT_W'(2) >= vec_cnt_reg)
                            state_next = ST_DRAIN;
                        else
                        begin
                            i_next = i_reg + SLOT_W'(1);
                            j_next = i_reg + SLOT_W'(2);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    w_next = w_reg + WIDX_W'(1);
                end
            end

            ST_DRAIN:
            begin
                if (!busy && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_common_next = best.common;
                    out_first_next  = swap ? best.second : best.first;
                    out_second_next = swap ? best.first : best.second;
                    out_ovf_next    = ovf_reg;
                    vec_cnt_next    = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State, control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            word_cnt_reg   <= '0;
            vec_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            last_pend_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            w_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_common_reg <= '0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_cnt_reg   <= word_cnt_next;
            vec_cnt_reg    <= vec_cnt_next;
            ovf_reg        <= ovf_next;
            last_pend_reg  <= last_pend_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            w_reg          <= w_next;
            out_valid_reg  <= out_valid_next;
            out_common_reg <= out_common_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    // Closing-vector length and per-word counts
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        for (int k = 0; k < MAX_VECTOR_WORDS; k++)
        begin
            pc_reg[k] <= pc_next[k];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_ovf_reg, out_second_reg, out_first_reg,
                       out_common_reg};

endmodule

// ===== src/mopu_pair_unit.sv =====
module mopu_pair_unit
    import mopu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  word_wr_t  word_wr,
    input  slot_wr_t  slot_wr,
    input  logic      clear_best,
    input  pair_cmd_t cmd,
    output best_t     best,
    output logic      busy
);

    // Vector store and per-slot info
    logic [DATA_W-1:0]   word_mem   [MAX_VECTORS * MAX_VECTOR_WORDS];
    logic [LEN_W-1:0]    len_mem    [MAX_VECTORS];
    logic [WEIGHT_W-1:0] weight_mem [MAX_VECTORS];

    // Read stage
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;
    logic [LEN_W-1:0]    len_a_reg;
    logic [LEN_W-1:0]    len_b_reg;
    logic [WEIGHT_W-1:0] wt_a_reg;
    logic [WEIGHT_W-1:0] wt_b_reg;
    pair_cmd_t           s1_reg;

    // Accumulate stage
    logic [COMMON_W-1:0] acc_reg;
    logic [COMMON_W-1:0] acc_next;
    logic [POP_W-1:0]    word_pop;
    logic                word_live;
    logic                s2_valid_reg;
    logic [COMMON_W-1:0] c_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [WEIGHT_W-1:0] wfirst_reg;
    logic [SLOT_W-1:0]   i_reg;
    logic [SLOT_W-1:0]   j_reg;

    // Compare stage
    best_t               best_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic                better;

    // Store writes and two-port registered reads
    always_ff @(posedge clk)
    begin
        if (word_wr.en)
        begin
            word_mem[word_wr.addr] <= word_wr.data;
        end
        if (slot_wr.en)
        begin
            len_mem[slot_wr.slot]    <= slot_wr.len;
            weight_mem[slot_wr.slot] <= slot_wr.weight;
        end
        rd_a_reg  <= word_mem[{cmd.i, cmd.w}];
        rd_b_reg  <= word_mem[{cmd.j, cmd.w}];
        len_a_reg <= len_mem[cmd.i];
        len_b_reg <= len_mem[cmd.j];
        wt_a_reg  <= weight_mem[cmd.i];
        wt_b_reg  <= weight_mem[cmd.j];
    end

    // Words past a slot's written length read as zero
    assign word_live = (LEN_W'(s1_reg.w) < len_a_reg) && (LEN_W'(s1_reg.w) < len_b_reg);
    assign word_pop  = word_live ? pop64(rd_a_reg & rd_b_reg) : '0;
    assign acc_next  = (s1_reg.first ? '0 : acc_reg) + COMMON_W'(word_pop);

    // Strictly more common ones, or a heavier pair while nothing overlaps
    assign better = s2_valid_reg &&
                    ((c_reg > best_reg.common) ||
                     ((c_reg == best_reg.common) && (best_reg.common == '0) &&
                      (sum_reg > best_sum_reg)));

    // Control of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            best_reg     <= '0;
            best_sum_reg <= '0;
        end
        else
        begin
            s1_reg       <= cmd;
            s2_valid_reg <= s1_reg.valid && s1_reg.last;
            if (clear_best)
            begin
                best_reg     <= '0;
                best_sum_reg <= '0;
            end
            else if (better)
            begin
                best_reg.common       <= c_reg;
                best_reg.first        <= i_reg;
                best_reg.second       <= j_reg;
                best_reg.first_weight <= wfirst_reg;
                best_sum_reg          <= sum_reg;
            end
        end
    end

    // Pair payload
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            acc_reg    <= acc_next;
            c_reg      <= acc_next;
            sum_reg    <= SUM_W'(wt_a_reg) + SUM_W'(wt_b_reg);
            wfirst_reg <= wt_a_reg;
            i_reg      <= s1_reg.i;
            j_reg      <= s1_reg.j;
        end
    end

    assign best = best_reg;
    assign busy = s1_reg.valid || s2_valid_reg;

endmodule

// ===== src/mopu_checker.sv =====
`include "max_overlap_vector_pair_unit_defines.svh"

module mopu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result holds
    `MOPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The final word of a set starts work, so no word is taken right after it
    `MOPU_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready, "input taken right after last word")

    // Overlap never exceeds the widest vector
    `MOPU_ASSERT_IMPLY(a_common_range, m_tvalid, m_tdata[8:0] <= 9'd256, "common count out of range")

    // A nonzero overlap always comes from two distinct vectors
    `MOPU_ASSERT_IMPLY(a_pair_distinct, m_tvalid && (m_tdata[8:0] != 9'd0), m_tdata[12:9] != m_tdata[16:13], "pair indices equal")

endmodule

bind max_overlap_vector_pair_unit mopu_checker u_mopu_checker (.*);
